[sv/rtte_pkg.sv]
// Shared types, constants and register map of the RTT and RTO estimator.
`default_nettype none

package rtte_pkg;

    localparam int TIME_BITS_DEFAULT  = 32;
    localparam int GAIN_SHIFT_DEFAULT = 3;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MIN_TIMEOUT = 1'b0;
    localparam logic REG_MAX_TIMEOUT = 1'b1;

    localparam logic [31:0] MIN_TIMEOUT_RESET = 32'd200000;
    localparam logic [31:0] MAX_TIMEOUT_RESET = 32'd240000000;

    localparam int IN_DATA_BITS  = 96;
    localparam int OUT_FIELD_BITS = 194;
    localparam int OUT_DATA_BITS = 200;

    typedef struct packed {
        logic [31:0] max_timeout;
        logic [31:0] min_timeout;
    } cfg_t;

    typedef struct packed {
        logic [31:0] queue_delay;
        logic [31:0] acked_time;
        logic [31:0] sent_time;
    } item_t;

    typedef struct packed {
        logic [31:0]        lowest_srtt;
        logic signed [32:0] smoothed_corrected_rtt;
        logic signed [32:0] corrected_rtt;
        logic [31:0]        rtt_variance;
        logic [31:0]        smoothed_rtt;
        logic [31:0]        retransmit_timeout;
    } result_t;

endpackage

`default_nettype wire

[sv/rtte_cfg.sv]
// APB register file holding the timeout clamp bounds.
`default_nettype none

module rtte_cfg
    import rtte_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[APB_ADDR_BITS-1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_MIN_TIMEOUT: cfg_next.min_timeout = pwdata;
                REG_MAX_TIMEOUT: cfg_next.max_timeout = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MIN_TIMEOUT: prdata = cfg_reg.min_timeout;
            REG_MAX_TIMEOUT: prdata = cfg_reg.max_timeout;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_timeout <= MIN_TIMEOUT_RESET;
            cfg_reg.max_timeout <= MAX_TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/rtte_core.sv]
// Estimator state and the combinational smoothing, RTO and minimum update.
`default_nettype none

module rtte_core
    import rtte_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEFAULT,
    parameter int GAIN_SHIFT = GAIN_SHIFT_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  upd,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    res
);

    localparam int DIFF_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [31:0] srtt_reg;
    logic [31:0] srtt_next;
    logic [31:0] rttvar_reg;
    logic [31:0] rttvar_next;
    logic [31:0] corr_reg;
    logic [31:0] corr_next;
    logic [31:0] min_reg;
    logic [31:0] min_next;

    logic [DIFF_BITS-1:0] wide_diff;
    logic [DIFF_BITS-1:0] diff_masked;
    logic [31:0]          sample;
    logic signed [32:0]   est;
    logic [31:0]          srtt_base;
    logic signed [32:0]   err;
    logic signed [32:0]   err_sh;
    logic signed [32:0]   srtt_sum;
    logic [31:0]          abs_err;
    logic signed [32:0]   var_err;
    logic signed [32:0]   var_sh;
    logic signed [32:0]   var_sum;
    logic [31:0]          corr_base;
    logic signed [33:0]   corr_err;
    logic signed [33:0]   corr_sh;
    logic signed [33:0]   corr_sum;
    logic signed [32:0]   corr_new;
    logic [34:0]          rto_sum;
    logic [31:0]          rto_sat;
    logic [31:0]          rto;
    logic                 fallback;

    // The round-trip sample wraps at the timestamp width and saturates to 32 bits.
    assign wide_diff   = DIFF_BITS'(item.acked_time) - DIFF_BITS'(item.sent_time);
    assign diff_masked = wide_diff & ((DIFF_BITS'(1) << TIME_BITS) - DIFF_BITS'(1));
    assign sample      = (diff_masked > DIFF_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                 : diff_masked[31:0];

    assign est = $signed({1'b0, sample}) - $signed({1'b0, item.queue_delay});

    // A zero estimate means no sample yet, so it is seeded from this sample.
    assign srtt_base = (srtt_reg == '0) ? sample : srtt_reg;
    assign corr_base = (corr_reg == '0) ? sample : corr_reg;

    assign err      = $signed({1'b0, sample}) - $signed({1'b0, srtt_base});
    assign err_sh   = err >>> GAIN_SHIFT;
    assign srtt_sum = $signed({1'b0, srtt_base}) + err_sh;
    assign srtt_next = srtt_sum[31:0];

    assign abs_err  = err[32] ? 32'(-err) : err[31:0];
    assign var_err  = $signed({1'b0, abs_err}) - $signed({1'b0, rttvar_reg});
    assign var_sh   = var_err >>> GAIN_SHIFT;
    assign var_sum  = $signed({1'b0, rttvar_reg}) + var_sh;
    assign rttvar_next = var_sum[31:0];

    assign corr_err = $signed({est[32], est}) - $signed({2'b00, corr_base});
    assign corr_sh  = corr_err >>> GAIN_SHIFT;
    assign corr_sum = $signed({2'b00, corr_base}) + corr_sh;
    assign corr_new = corr_sum[32:0];

    assign rto_sum = {3'b000, srtt_next} + {1'b0, rttvar_next, 2'b00};
    assign rto_sat = (rto_sum[34:32] != 3'b000) ? 32'hFFFF_FFFF : rto_sum[31:0];

    always_comb
    begin
        priority if (rto_sat > cfg.max_timeout)
            rto = cfg.max_timeout;
        else if (rto_sat < cfg.min_timeout)
            rto = cfg.min_timeout;
        else
            rto = rto_sat;
    end

    assign min_next = (srtt_next < min_reg) ? srtt_next : min_reg;

    assign fallback = est[32] || (est == '0) || corr_new[32] || (corr_new == '0);

    assign res.retransmit_timeout     = rto;
    assign res.smoothed_rtt           = srtt_next;
    assign res.rtt_variance           = rttvar_next;
    assign res.corrected_rtt          = fallback ? $signed({1'b0, sample}) : est;
    assign res.smoothed_corrected_rtt = fallback ? $signed({1'b0, srtt_next}) : corr_new;
    assign res.lowest_srtt            = min_next;

    // The smoothed corrected value is never negative once stored.
    assign corr_next = res.smoothed_corrected_rtt[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srtt_reg   <= '0;
            rttvar_reg <= '0;
            corr_reg   <= '0;
            min_reg    <= '1;
        end
        else if (upd)
        begin
            srtt_reg   <= srtt_next;
            rttvar_reg <= rttvar_next;
            corr_reg   <= corr_next;
            min_reg    <= min_next;
        end
    end

`ifndef SYNTHESIS
    // With crossed bounds the lower bound wins whenever the upper one does not apply.
    a_rto_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> ((res.retransmit_timeout <= cfg.max_timeout)
                 || (res.retransmit_timeout == cfg.min_timeout)))
        else $error("retransmit timeout outside its clamp");

    a_min_not_above_srtt: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> (res.lowest_srtt <= res.smoothed_rtt))
        else $error("lowest srtt above current srtt");

    a_smoothed_corr_positive: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> !res.smoothed_corrected_rtt[32])
        else $error("smoothed corrected rtt negative");

    a_min_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (min_reg <= $past(min_reg)))
        else $error("minimum srtt increased");
`endif

endmodule

`default_nettype wire

[sv/rtt_rto_estimator.sv]
// Top level of the RTT and RTO estimator: stream handshakes, pipeline and registers.
//
//   port group   dir   word contents
//   s_axis_*     in    one RTT sample: send time, ack time, queueing delay
//   m_axis_*     out   one estimate: RTO, srtt, rttvar, corrected, smoothed, lowest
//   APB          in    min_timeout at 0x0, max_timeout at 0x4
//
// A word is captured in the input register, passes the update logic into the
// output register and leaves from there once m_axis takes it. One word is
// accepted every cycle unless m_axis stalls; the srtt state updates as it advances.
// Reset clears the estimator state and reloads the default timeout bounds.
// A stall on m_axis holds both stages; s_axis_tready drops only when both are full.
`default_nettype none

module rtt_rto_estimator
    import rtte_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEFAULT,
    parameter int GAIN_SHIFT = GAIN_SHIFT_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // s_axis_tdata: sent_time [31:0], acked_time [63:32], queue_delay [95:64]
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // m_axis_tdata: retransmit_timeout [31:0], smoothed_rtt [63:32],
    // rtt_variance [95:64], corrected_rtt [128:96],
    // smoothed_corrected_rtt [161:129], lowest_srtt [193:162], zeros above
    output logic      [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    in_take;
    logic    advance;

    assign pready = 1'b1;

    rtte_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_t'(s_axis_tdata);
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    rtte_core #(
        .TIME_BITS  (TIME_BITS),
        .GAIN_SHIFT (GAIN_SHIFT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}}, out_reg};

`ifndef SYNTHESIS
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with a free pipeline stage");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word did not reach the output register");

    a_output_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_axis_tready && !advance) |=> !out_valid_reg)
        else $error("delivered word left valid");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking stream testbench for the RTT and RTO estimator.
`default_nettype none

module testbench
    import rtte_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 100;
    localparam int REPORT_LIMIT = 10;

    // Tracks the estimator state and holds the estimates still owed by the block.
    class rto_tracker;
        logic [31:0] srtt;
        logic [31:0] rttvar;
        logic [31:0] lowest;
        logic [31:0] min_bound;
        logic [31:0] max_bound;
        longint      corr_srtt;
        result_t     owed_q[$];
        int          mismatches;
        int          checked;

        function new();
            srtt = '0;
            rttvar = '0;
            lowest = '1;
            corr_srtt = 0;
            min_bound = MIN_TIMEOUT_RESET;
            max_bound = MAX_TIMEOUT_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_bound(logic reg_index, logic [31:0] value);
            if (reg_index == REG_MIN_TIMEOUT)
                min_bound = value;
            else
                max_bound = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void flag(string what, logic [32:0] want, logic [32:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch %s: expected 0x%09h, got 0x%09h at %0t",
                         what, want, got, $realtime);
        endfunction

        function void check_field(string what, logic [32:0] want, logic [32:0] got);
            if (want !== got)
                flag(what, want, got);
        endfunction

        function void absorb_sample(item_t word);
            logic [31:0] sample;
            longint      est;
            longint      srtt64;
            longint      var64;
            longint      err;
            longint      est_err;
            longint      abs_err;
            longint      acc;
            longint      rto;
            result_t     due;

            // The sample is taken modulo 2^32, so a wrapped clock still gives
            // the true round trip.
            sample = word.acked_time - word.sent_time;
            est = longint'({32'b0, sample}) - longint'({32'b0, word.queue_delay});

            if (srtt == 0)
                srtt = sample;
            if (corr_srtt == 0)
                corr_srtt = longint'({32'b0, sample});

            srtt64 = longint'({32'b0, srtt});
            var64 = longint'({32'b0, rttvar});
            err = longint'({32'b0, sample}) - srtt64;
            est_err = est - corr_srtt;
            abs_err = (err < 0) ? -err : err;

            acc = srtt64 + (err >>> GAIN_SHIFT_DEFAULT);
            srtt = acc[31:0];
            acc = var64 + ((abs_err - var64) >>> GAIN_SHIFT_DEFAULT);
            rttvar = acc[31:0];
            corr_srtt = corr_srtt + (est_err >>> GAIN_SHIFT_DEFAULT);

            rto = longint'({32'b0, srtt}) + (longint'({32'b0, rttvar}) <<< 2);
            if (rto > longint'({32'b0, 32'hFFFF_FFFF}))
                rto = longint'({32'b0, 32'hFFFF_FFFF});
            if (rto > longint'({32'b0, max_bound}))
                rto = longint'({32'b0, max_bound});
            else if (rto < longint'({32'b0, min_bound}))
                rto = longint'({32'b0, min_bound});

            if (srtt < lowest)
                lowest = srtt;

            // A corrected value at or below zero falls back to the raw figures.
            if (est <= 0 || corr_srtt <= 0)
            begin
                est = longint'({32'b0, sample});
                corr_srtt = longint'({32'b0, srtt});
            end

            due.retransmit_timeout = rto[31:0];
            due.smoothed_rtt = srtt;
            due.rtt_variance = rttvar;
            due.corrected_rtt = est[32:0];
            due.smoothed_corrected_rtt = corr_srtt[32:0];
            due.lowest_srtt = lowest;
            owed_q.push_back(due);
        endfunction

        function void compare_estimate(result_t got);
            result_t want;

            if (owed_q.size() == 0)
            begin
                flag("unexpected estimate", '0, got.retransmit_timeout);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            check_field("retransmit_timeout", want.retransmit_timeout,
                        got.retransmit_timeout);
            check_field("smoothed_rtt", want.smoothed_rtt, got.smoothed_rtt);
            check_field("rtt_variance", want.rtt_variance, got.rtt_variance);
            check_field("corrected_rtt", want.corrected_rtt, got.corrected_rtt);
            check_field("smoothed_corrected_rtt", want.smoothed_corrected_rtt,
                        got.smoothed_corrected_rtt);
            check_field("lowest_srtt", want.lowest_srtt, got.lowest_srtt);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    rto_tracker  board = new();
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_us;
    logic [31:0] base_rtt = 32'd20000;

    rtt_rto_estimator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: checks each accepted word, then decides whether to stall.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.compare_estimate(m_axis_tdata[OUT_FIELD_BITS-1:0]);
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("No word moved for %0d cycles, %0d estimates outstanding.",
                     STALL_LIMIT, board.pending());
            $display("FAIL rtt_rto_estimator");
            $finish;
        end
    end

    function automatic item_t pack_sample(logic [31:0] sent, logic [31:0] acked,
                                          logic [31:0] qd);
        item_t word;

        word.sent_time = sent;
        word.acked_time = acked;
        word.queue_delay = qd;
        return word;
    endfunction

    // Mostly plausible traffic around a drifting base RTT, with some noise.
    function item_t make_sample();
        item_t       word;
        logic [31:0] rtt;
        int          roll;

        roll = $urandom_range(99);
        if (roll < 8)
            return pack_sample($urandom, $urandom, $urandom);
        if ($urandom_range(19) == 0)
            base_rtt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000000, 500);
        rtt = (roll < 11) ? 32'd0 : base_rtt + $urandom_range(base_rtt / 4);
        clock_us = clock_us + $urandom_range(5000, 1);
        word.sent_time = clock_us;
        word.acked_time = clock_us + rtt;
        roll = $urandom_range(99);
        if (roll < 55)
            word.queue_delay = $urandom_range(rtt / 2);
        else if (roll < 70)
            word.queue_delay = rtt;
        else if (roll < 85)
            word.queue_delay = rtt + $urandom_range(1000, 1);
        else
            word.queue_delay = $urandom;
        return word;
    endfunction

    task automatic send_sample(input item_t word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.absorb_sample(word);
        words_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Each transfer ends by returning the bus to idle so that the next one starts a clean setup.
    task automatic write_register(input logic reg_index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_bound(reg_index, value);
        @(posedge clk);
    endtask

    task automatic read_register(input logic reg_index, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.check_field(reg_index == REG_MIN_TIMEOUT ? "min_timeout read"
                                                       : "max_timeout read",
                          {1'b0, want}, {1'b0, prdata});
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bounds(input logic [31:0] lo, input logic [31:0] hi);
        write_register(REG_MIN_TIMEOUT, lo);
        write_register(REG_MAX_TIMEOUT, hi);
        read_register(REG_MIN_TIMEOUT, lo);
        read_register(REG_MAX_TIMEOUT, hi);
    endtask

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        clock_us = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_register(REG_MIN_TIMEOUT, MIN_TIMEOUT_RESET);
        read_register(REG_MAX_TIMEOUT, MAX_TIMEOUT_RESET);
        set_bounds(32'd0, 32'hFFFF_FFFF);

        // Opening words: zero samples, a smoothed value falling back to zero,
        // corrected values at and below zero, clock wrap, saturated RTO and
        // every bit of each field in both states.
        send_sample(pack_sample(32'd0, 32'd0, 32'd0));
        send_sample(pack_sample(32'd7, 32'd8, 32'd0));
        send_sample(pack_sample(32'd9, 32'd9, 32'd0));
        send_sample(pack_sample(32'd100, 32'd5100, 32'd1000));
        send_sample(pack_sample(32'd0, 32'd5000, 32'd5000));
        send_sample(pack_sample(32'd0, 32'd5000, 32'd9000));
        send_sample(pack_sample(32'hFFFF_FF00, 32'd1000, 32'd0));
        send_sample(pack_sample(32'd1, 32'd0, 32'd0));
        send_sample(pack_sample(32'd1, 32'd0, 32'hFFFF_FFFF));
        send_sample(pack_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_sample(pack_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        send_sample(pack_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        send_sample(pack_sample(32'hFFFF_FFFF, 32'd0, 32'd1));
        send_sample(pack_sample(32'd0, 32'hFFFF_FFFF, 32'd0));
        send_sample(pack_sample(32'd0, 32'd3000, 32'd100));
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            case (phase)
                0: begin lo = 32'd0; hi = 32'hFFFF_FFFF; end
                1: begin lo = 32'hFFFF_FFFF; hi = 32'd0; end
                2: begin lo = MIN_TIMEOUT_RESET; hi = MAX_TIMEOUT_RESET; end
                3: begin lo = $urandom_range(300000); hi = lo + $urandom_range(5000000); end
                4: begin lo = $urandom_range(1000000, 1); hi = lo; end
                5: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; end
                6: begin lo = $urandom; hi = $urandom; end
                default: begin lo = 32'd0; hi = 32'd0; end
            endcase
            set_bounds(lo, hi);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Halfway through, let the pipeline run completely dry.
                if (n == WORDS_PER_PHASE / 2)
                    settle();
                send_sample(make_sample());
            end
            settle();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d samples and checked %0d estimates across %0d bound settings,",
                 words_sent, board.checked, RANDOM_PHASES + 1);
        $display("with back-to-back, sender-idle, receiver-stall and mixed traffic.");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS rtt_rto_estimator");
        else
            $display("FAIL rtt_rto_estimator");
        $finish;
    end

endmodule

`default_nettype wire
